// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the decimal converter.
// Each macro wraps one clocked concurrent assertion with an active-low reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge while reset is released.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/b2d_pkg.sv =====
// Package for the binary to decimal ASCII converter.
// Holds the digit cell control struct and fixed constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b2d_pkg;

    localparam int MAX_DIGITS = 10;
    localparam int FIELD_BITS = 32;
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    // Control that the sequencer drives into every digit cell.
    typedef struct packed {
        logic clear;
        logic dabble;
        logic move;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== hw/rtl/binary_to_decimal_ascii.sv =====
// A request shifts its min(VALUE_BITS,32) input bits into the digit chain, then sizes
// the result and shifts out the ten digits; busy is high through all three steps.
// A new request is taken only when idle, once the previous one has shifted out all
// its digits; the pace is set by the bit-serial dabble.
// Digits leave on one-cycle strobes that the receiver cannot stall.
// Reset is synchronous and active low; it returns the sequencer to idle and drops the strobe.
// Top level of the converter; uses b2d_pkg, b2d_cell and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    output logic [5:0]       o_digit_char,
    output logic [3:0]       o_digit_count,
    output logic             o_last_digit
);
    import b2d_pkg::*;
    `include "assert_macros.svh"

    localparam int EFF_BITS  = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam int BIT_CNT_W = (EFF_BITS > 2) ? $clog2(EFF_BITS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIZE,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic [EFF_BITS-1:0]  r_shift;
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic [3:0]           r_dig_cnt;
    logic [3:0]           r_count;
    logic [3:0]           n_count;
    logic [4:0]           w_pos_sum;

    t_cell_ctrl           w_ctrl;
    logic                 w_carry [MAX_DIGITS+1];
    logic [3:0]           w_digit [MAX_DIGITS+1];
    logic                 w_accept;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    always_comb begin
        w_ctrl.clear  = w_accept;
        w_ctrl.dabble = (r_state == S_CONV);
        w_ctrl.move   = (r_state == S_EMIT);
    end

    // The chain input: the next binary bit for the dabble, a zero digit for the shift-out.
    assign w_carry[0] = r_shift[EFF_BITS-1];
    assign w_digit[0] = 4'd0;

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        b2d_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_carry(w_carry[g]),
            .i_digit(w_digit[g]),
            .o_carry(w_carry[g+1]),
            .o_digit(w_digit[g+1])
        );
    end

    // Digit count is one above the highest nonzero digit, and one for zero.
    always_comb begin
        n_count = 4'd1;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (w_digit[i+1] != 4'd0) begin
                n_count = 4'(i + 1);
            end
        end
    end

    // Leading zeros are shifted out silently; a digit is shown once the position
    // reaches the first significant one.
    assign w_pos_sum = {1'b0, r_dig_cnt} + {1'b0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_shift   <= i_value[EFF_BITS-1:0];
                        r_bit_cnt <= '0;
                        r_state   <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_shift   <= r_shift << 1;
                    r_bit_cnt <= r_bit_cnt + 1'b1;
                    if (r_bit_cnt == BIT_CNT_W'(EFF_BITS - 1)) begin
                        r_state <= S_SIZE;
                    end
                end
                S_SIZE: begin
                    r_count   <= n_count;
                    r_dig_cnt <= 4'd0;
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    r_dig_cnt <= r_dig_cnt + 4'd1;
                    if (w_pos_sum >= 5'(MAX_DIGITS)) begin
                        o_valid <= 1'b1;
                    end
                    o_digit_char  <= ASCII_ZERO + {2'b00, w_digit[MAX_DIGITS]};
                    o_digit_count <= r_count;
                    o_last_digit  <= (r_dig_cnt == 4'(MAX_DIGITS - 1));
                    if (r_dig_cnt == 4'(MAX_DIGITS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, busy, "request accepted but not busy")
    `ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_valid && o_last_digit, !o_valid,
        "strobe after the final digit")
    `ASSERT_IMPL(a_char_range, i_clk, i_rst_n, o_valid,
        (o_digit_char >= 6'd48) && (o_digit_char <= 6'd57), "digit character out of range")
    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, o_valid,
        (o_digit_count != 4'd0) && (o_digit_count <= 4'd10), "digit count out of range")

endmodule

`default_nettype wire

// ===== hw/rtl/b2d_cell.sv =====
// One BCD digit cell of the double dabble chain.
// Depends on b2d_pkg for the cell control struct.
`timescale 1ns / 1ps
`default_nettype none

module b2d_cell (
    input  wire logic                i_clk,
    input  wire b2d_pkg::t_cell_ctrl i_ctrl,
    input  wire logic                i_carry,
    input  wire logic [3:0]          i_digit,
    output logic                     o_carry,
    output logic [3:0]               o_digit
);
    import b2d_pkg::*;

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // Add three before the shift so a digit of five or more carries out.
    always_comb begin
        w_adj = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
        o_carry = w_adj[3];
        o_digit = r_digit;
    end

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctrl.dabble) begin
            n_digit = {w_adj[2:0], i_carry};
        end else if (i_ctrl.move) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

`default_nettype wire
